// ----- rtl/utqb_pkg.sv -----
package utqb_pkg;

  localparam int DEPTH = 16;
  localparam int PTR_W = $clog2(DEPTH);

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_READY = 1'b1;

  typedef struct packed {
    logic       opcode;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic       send_valid;
    logic [7:0] send_byte;
    logic       full_error;
    logic       busy_res;
  } out_t;

  typedef struct packed {
    logic take;
  } cmd_t;

endpackage

// ----- rtl/utqb_ctrl.sv -----
module utqb_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output utqb_pkg::cmd_t cmd
);
  import utqb_pkg::*;

  typedef enum logic {ST_IDLE, ST_OUT} state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_valid) state_nxt = ST_OUT;
      ST_OUT:  if (out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign cmd.take  = in_ready && in_valid;

endmodule

// ----- rtl/utqb_dp.sv -----
module utqb_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  utqb_pkg::cmd_t cmd,
  input  utqb_pkg::in_t  in_data,
  output utqb_pkg::out_t out_data
);
  import utqb_pkg::*;

  logic [7:0]       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic             sending_r;
  logic [PTR_W-1:0] wr_inc, rd_inc;
  logic             res_valid_r, res_full_r, use_mem_r;
  logic [7:0]       byte_r, rd_data_r;

  assign wr_inc = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
  assign rd_inc = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;

  // control state: pointers and busy flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= '0;
      rd_ptr_r  <= '0;
      sending_r <= 1'b0;
    end else if (cmd.take) begin
      if (in_data.opcode == OP_WRITE) begin
        if (!sending_r) begin
          sending_r <= 1'b1;
        end else if (wr_inc != rd_ptr_r) begin
          wr_ptr_r <= wr_inc;
        end
      end else if (sending_r) begin
        if (wr_ptr_r == rd_ptr_r) begin
          sending_r <= 1'b0;
        end else begin
          rd_ptr_r <= rd_inc;
        end
      end
    end
  end

  // ring storage, registered read
  always_ff @(posedge clk) begin
    if (cmd.take && in_data.opcode == OP_WRITE && sending_r && wr_inc != rd_ptr_r) begin
      mem[wr_ptr_r] <= in_data.data_byte;
    end
    if (cmd.take && in_data.opcode == OP_READY) begin
      rd_data_r <= mem[rd_ptr_r];
    end
  end

  // result flags, held until the next request
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      res_valid_r <= 1'b0;
      res_full_r  <= 1'b0;
      use_mem_r   <= 1'b0;
      byte_r      <= 8'h00;
      if (in_data.opcode == OP_WRITE) begin
        if (!sending_r) begin
          res_valid_r <= 1'b1;
          byte_r      <= in_data.data_byte;
        end else if (wr_inc == rd_ptr_r) begin
          res_full_r <= 1'b1;
        end
      end else if (sending_r && wr_ptr_r != rd_ptr_r) begin
        res_valid_r <= 1'b1;
        use_mem_r   <= 1'b1;
      end
    end
  end

  assign out_data.send_valid = res_valid_r;
  assign out_data.send_byte  = use_mem_r ? rd_data_r : byte_r;
  assign out_data.full_error = res_full_r;
  assign out_data.busy_res   = sending_r;

endmodule

// ----- rtl/uart_tx_queue_with_bypass_unit.sv -----
// Channel   Ports                            Moves
// input     in_valid / in_ready / in_data    one request: write byte or transmitter ready
// result    out_valid / out_ready / out_data one result per request
//
// On each request the accept cycle updates pointers, busy flag
// and the ring, the next cycle presents the result from registers.
// The ring read port is registered, so ring bytes also reach the output from a register.
// A new request is accepted only after the previous result is taken.
// Synchronous active-low reset clears pointers, busy flag and handshake state;
// ring contents stay undefined until written.
module uart_tx_queue_with_bypass_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  utqb_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output utqb_pkg::out_t out_data
);
  import utqb_pkg::*;

  cmd_t cmd;

  // sequence accept and delivery
  utqb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // hold the ring, pointers and result
  utqb_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

  // one request in flight: never ready for input while a result is pending
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && in_ready))
    else $error("input ready while result pending");

  // an accepted request yields a result in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> out_valid)
    else $error("no result after accepted request");

  // a dropped write never sends a byte
  a_full_no_send: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.full_error && out_data.send_valid))
    else $error("full_error with send_valid");

  // a result that sends nothing carries a zero byte
  a_idle_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.send_valid) |-> (out_data.send_byte == 8'h00))
    else $error("nonzero byte without send_valid");

endmodule
